// File: rtl/svdr_pkg.sv
package svdr_pkg;

   // Build constants
   localparam int MAX_VALUES = 8;
   localparam int IDX_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_W      = 32;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SPAN  = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   // Register indexes
   localparam logic [2:0] REG_FMT        = 3'd0;
   localparam logic [2:0] REG_DEC_PLACES = 3'd1;
   localparam logic [2:0] REG_VAL_COUNT  = 3'd2;
   localparam logic [2:0] REG_RAW_MIN    = 3'd3;
   localparam logic [2:0] REG_RAW_MAX    = 3'd4;
   localparam logic [2:0] REG_SI_MIN     = 3'd5;
   localparam logic [2:0] REG_SI_MAX     = 3'd6;

   // Data type codes
   localparam logic [2:0] DT_U8    = 3'd0;
   localparam logic [2:0] DT_S8    = 3'd1;
   localparam logic [2:0] DT_U16   = 3'd2;
   localparam logic [2:0] DT_S16   = 3'd3;
   localparam logic [2:0] DT_S16BE = 3'd4;
   localparam logic [2:0] DT_U32   = 3'd5;
   localparam logic [2:0] DT_S32   = 3'd6;
   localparam logic [2:0] DT_FLOAT = 3'd7;

   // Sideband that travels with every item
   typedef struct packed {
      logic       vld;
      logic [1:0] err;
      logic       sat;
   } side_type;

   typedef struct packed {
      logic [2:0]  fmt;
      logic [3:0]  dec_places;
      logic [3:0]  val_count;
      logic [31:0] raw_min;
      logic [31:0] raw_max;
      logic [31:0] si_min;
      logic [31:0] si_max;
   } cfg_type;

   // 10^dp, dp clamped to nine
   function automatic logic [29:0] pow10(input logic [3:0] dp);
      logic [29:0] r;
      case (dp)
         4'd0: r = 30'd1;
         4'd1: r = 30'd10;
         4'd2: r = 30'd100;
         4'd3: r = 30'd1000;
         4'd4: r = 30'd10000;
         4'd5: r = 30'd100000;
         4'd6: r = 30'd1000000;
         4'd7: r = 30'd10000000;
         4'd8: r = 30'd100000000;
         default: r = 30'd1000000000;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/svdr_decode.sv
module svdr_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_vld,
   input  logic [2:0]               in_idx,
   input  logic [31:0]              in_word,
   input  svdr_pkg::cfg_type        cfg,
   output svdr_pkg::side_type       out_side,
   output logic [31:0]              out_v
);
   import svdr_pkg::*;

   // Stage 1: range checks, integer decode, mantissa times 10^dp
   side_type    s1_side_in, s1_side_ff;
   logic [31:0] s1_int_in, s1_int_ff;
   logic        s1_flt_ff, s1_neg_ff;
   logic [7:0]  s1_exp_ff;
   logic [53:0] s1_prod_in, s1_prod_ff;
   logic [15:0] be16;

   always_comb begin
      s1_side_in.vld = in_vld;
      s1_side_in.sat = 1'b0;
      if (({1'b0, in_idx} >= cfg.val_count) || (int'(in_idx) >= MAX_VALUES)) begin
         s1_side_in.err = ST_RANGE;
      end else if (cfg.raw_max == cfg.raw_min) begin
         s1_side_in.err = ST_SPAN;
      end else begin
         s1_side_in.err = ST_OK;
      end
      be16 = {in_word[7:0], in_word[15:8]};
      case (cfg.fmt)
         DT_U8:    s1_int_in = {24'd0, in_word[7:0]};
         DT_S8:    s1_int_in = {{24{in_word[7]}}, in_word[7:0]};
         DT_U16:   s1_int_in = {16'd0, in_word[15:0]};
         DT_S16:   s1_int_in = {{16{in_word[15]}}, in_word[15:0]};
         DT_S16BE: s1_int_in = {{16{be16[15]}}, be16};
         default:  s1_int_in = in_word;
      endcase
      s1_prod_in = {30'd0, 1'b1, in_word[22:0]} * {24'd0, pow10(cfg.dec_places)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.vld <= 1'b0;
      end else begin
         s1_side_ff.vld <= s1_side_in.vld;
      end
      s1_side_ff.err <= s1_side_in.err;
      s1_side_ff.sat <= s1_side_in.sat;
      s1_int_ff      <= s1_int_in;
      s1_flt_ff      <= (cfg.fmt == DT_FLOAT);
      s1_neg_ff      <= in_word[31];
      s1_exp_ff      <= in_word[30:23];
      s1_prod_ff     <= s1_prod_in;
   end

   // Stage 2: integers pass through; float shift with half-up rounding and clamp
   side_type    s2_side_in, s2_side_ff;
   logic [31:0] s2_v_in, s2_v_ff;
   logic [63:0] limit, mag, prod;
   logic [7:0]  k;
   logic        over;

   always_comb begin
      s2_side_in = s1_side_ff;
      limit = s1_neg_ff ? 64'h8000_0000 : 64'h7FFF_FFFF;
      prod  = {10'd0, s1_prod_ff};
      mag   = 64'd0;
      k     = 8'd0;
      over  = 1'b0;
      if (!s1_flt_ff) begin
         s2_v_in = s1_int_ff;
      end else if (s1_exp_ff == 8'd0) begin
         s2_v_in = 32'd0;
      end else begin
         if (s1_exp_ff == 8'd255) begin
            over = 1'b1;
         end else if (s1_exp_ff < 8'd150) begin
            k = 8'd150 - s1_exp_ff;
            if (k >= 8'd64) begin
               mag = 64'd0;
            end else begin
               mag = (prod + (64'd1 << (k[5:0] - 6'd1))) >> k[5:0];
            end
         end else begin
            k = s1_exp_ff - 8'd150;
            if (k >= 8'd40) begin
               over = 1'b1;
            end else begin
               over = prod > (limit >> k[5:0]);
               mag  = prod << k[5:0];
            end
         end
         if (over || (mag > limit)) begin
            s2_side_in.sat = 1'b1;
            mag = limit;
         end
         s2_v_in = s1_neg_ff ? (32'd0 - mag[31:0]) : mag[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff.vld <= 1'b0;
      end else begin
         s2_side_ff.vld <= s2_side_in.vld;
      end
      s2_side_ff.err <= s2_side_in.err;
      s2_side_ff.sat <= s2_side_in.sat;
      s2_v_ff        <= s2_v_in;
   end

   assign out_side = s2_side_ff;
   assign out_v    = s2_v_ff;

endmodule

// File: rtl/svdr_mult.sv
module svdr_mult (
   input  logic                clock,
   input  logic                reset,
   input  svdr_pkg::side_type  in_side,
   input  logic [31:0]         in_v,
   input  svdr_pkg::cfg_type   cfg,
   output svdr_pkg::side_type  out_side,
   output logic                out_neg,
   output logic [64:0]         out_prod,
   output logic [32:0]         out_md
);
   import svdr_pkg::*;

   // Stage 3: differences and their magnitudes
   logic [32:0] a, b, d;
   side_type    s3_side_ff;
   logic [32:0] s3_ma_ff, s3_mb_ff, s3_md_ff;
   logic        s3_neg_ff;

   always_comb begin
      a = {in_v[31], in_v} - {cfg.raw_min[31], cfg.raw_min};
      b = {cfg.si_max[31], cfg.si_max} - {cfg.si_min[31], cfg.si_min};
      d = {cfg.raw_max[31], cfg.raw_max} - {cfg.raw_min[31], cfg.raw_min};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff.vld <= 1'b0;
      end else begin
         s3_side_ff.vld <= in_side.vld;
      end
      s3_side_ff.err <= in_side.err;
      s3_side_ff.sat <= in_side.sat;
      s3_ma_ff  <= a[32] ? (33'd0 - a) : a;
      s3_mb_ff  <= b[32] ? (33'd0 - b) : b;
      s3_md_ff  <= d[32] ? (33'd0 - d) : d;
      s3_neg_ff <= (a[32] ^ b[32]) ^ d[32];
   end

   // Stage 4: two partial products
   side_type    s4_side_ff;
   logic [49:0] s4_lo_ff;
   logic [48:0] s4_hi_ff;
   logic [32:0] s4_md_ff;
   logic        s4_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_side_ff.vld <= 1'b0;
      end else begin
         s4_side_ff.vld <= s3_side_ff.vld;
      end
      s4_side_ff.err <= s3_side_ff.err;
      s4_side_ff.sat <= s3_side_ff.sat;
      s4_lo_ff  <= {17'd0, s3_ma_ff} * {33'd0, s3_mb_ff[16:0]};
      s4_hi_ff  <= {16'd0, s3_ma_ff} * {33'd0, s3_mb_ff[32:17]};
      s4_md_ff  <= s3_md_ff;
      s4_neg_ff <= s3_neg_ff;
   end

   // Stage 5: sum of partial products
   side_type    s5_side_ff;
   logic [65:0] sum;
   logic [64:0] s5_prod_ff;
   logic [32:0] s5_md_ff;
   logic        s5_neg_ff;

   assign sum = {16'd0, s4_lo_ff} + {s4_hi_ff, 17'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_side_ff.vld <= 1'b0;
      end else begin
         s5_side_ff.vld <= s4_side_ff.vld;
      end
      s5_side_ff.err <= s4_side_ff.err;
      s5_side_ff.sat <= s4_side_ff.sat;
      s5_prod_ff <= sum[64:0];
      s5_md_ff   <= s4_md_ff;
      s5_neg_ff  <= s4_neg_ff;
   end

   assign out_side = s5_side_ff;
   assign out_neg  = s5_neg_ff;
   assign out_prod = s5_prod_ff;
   assign out_md   = s5_md_ff;

endmodule

// File: rtl/svdr_div.sv
module svdr_div (
   input  logic                clock,
   input  logic                reset,
   input  svdr_pkg::side_type  in_side,
   input  logic                in_neg,
   input  logic [64:0]         in_prod,
   input  logic [32:0]         in_md,
   output svdr_pkg::side_type  out_side,
   output logic                out_neg,
   output logic                out_ovf,
   output logic [32:0]         out_q
);
   import svdr_pkg::*;

   localparam int QW = 33;

   side_type    side_ff [0:QW];
   logic        neg_ff  [0:QW];
   logic        ovf_ff  [0:QW];
   logic [64:0] rem_ff  [0:QW];
   logic [32:0] md_ff   [0:QW];
   logic [32:0] q_ff    [0:QW];

   // Entry stage: quotient above 2^32 is flagged, so 33 quotient bits suffice
   logic [65:0] ovf_bound;
   assign ovf_bound = {1'b0, in_md, 32'd0} + {33'd0, in_md};

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].vld <= 1'b0;
      end else begin
         side_ff[0].vld <= in_side.vld;
      end
      side_ff[0].err <= in_side.err;
      side_ff[0].sat <= in_side.sat;
      neg_ff[0] <= in_neg;
      ovf_ff[0] <= {1'b0, in_prod} >= ovf_bound;
      rem_ff[0] <= in_prod;
      md_ff[0]  <= in_md;
      q_ff[0]   <= 33'd0;
   end

   // One restoring step per stage, most significant quotient bit first
   for (genvar j = 0; j < QW; j++) begin : g_step
      logic [64:0] dv;
      logic [65:0] diff;

      always_comb begin
         dv   = {32'd0, md_ff[j]} << (QW - 1 - j);
         diff = {1'b0, rem_ff[j]} - {1'b0, dv};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j+1].vld <= 1'b0;
         end else begin
            side_ff[j+1].vld <= side_ff[j].vld;
         end
         side_ff[j+1].err <= side_ff[j].err;
         side_ff[j+1].sat <= side_ff[j].sat;
         neg_ff[j+1] <= neg_ff[j];
         ovf_ff[j+1] <= ovf_ff[j];
         md_ff[j+1]  <= md_ff[j];
         rem_ff[j+1] <= diff[65] ? rem_ff[j] : diff[64:0];
         q_ff[j+1]   <= {q_ff[j][31:0], ~diff[65]};
      end
   end

   assign out_side = side_ff[QW];
   assign out_neg  = neg_ff[QW];
   assign out_ovf  = ovf_ff[QW];
   assign out_q    = q_ff[QW];

endmodule

// File: rtl/sensor_value_decode_and_rescale_top.sv
// Channel   Ports                                    Handshake
// request   req_value_index, req_raw_word            start & !busy, busy always low
// result    rsp_scaled_value, rsp_status             rsp_valid strobe, one cycle
// config    csr_we, csr_index, csr_wdata             csr_we, write at the edge
//
// One item enters every cycle; each result passes through two decode stages,
// three multiply stages, an overflow check, 33 one-bit divide stages and
// the output register.
// Synchronous active-high reset clears the valid bits and loads the configuration registers with their defaults.
// The pipeline never stalls since the result side cannot hold off.
module sensor_value_decode_and_rescale_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [svdr_pkg::IDX_W-1:0]     req_value_index,
   input  logic [31:0]                    req_raw_word,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_scaled_value,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_we,
   input  logic [svdr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [svdr_pkg::CSR_W-1:0]     csr_wdata
);
   import svdr_pkg::*;

   // Configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fmt        <= DT_U8;
         cfg_ff.dec_places <= 4'd0;
         cfg_ff.val_count  <= 4'd1;
         cfg_ff.raw_min    <= 32'd0;
         cfg_ff.raw_max    <= 32'd1;
         cfg_ff.si_min     <= 32'd0;
         cfg_ff.si_max     <= 32'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_FMT:        cfg_ff.fmt        <= csr_wdata[2:0];
            REG_DEC_PLACES: cfg_ff.dec_places <= csr_wdata[3:0];
            REG_VAL_COUNT:  cfg_ff.val_count  <= csr_wdata[3:0];
            REG_RAW_MIN:    cfg_ff.raw_min    <= csr_wdata;
            REG_RAW_MAX:    cfg_ff.raw_max    <= csr_wdata;
            REG_SI_MIN:     cfg_ff.si_min     <= csr_wdata;
            REG_SI_MAX:     cfg_ff.si_max     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   side_type    dec_side, mul_side, div_side;
   logic [31:0] dec_v;
   logic        mul_neg, div_neg, div_ovf;
   logic [64:0] mul_prod;
   logic [32:0] mul_md, div_q;

   svdr_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (start & ~busy),
      .in_idx   (req_value_index),
      .in_word  (req_raw_word),
      .cfg      (cfg_ff),
      .out_side (dec_side),
      .out_v    (dec_v)
   );

   svdr_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .in_side  (dec_side),
      .in_v     (dec_v),
      .cfg      (cfg_ff),
      .out_side (mul_side),
      .out_neg  (mul_neg),
      .out_prod (mul_prod),
      .out_md   (mul_md)
   );

   svdr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_side  (mul_side),
      .in_neg   (mul_neg),
      .in_prod  (mul_prod),
      .in_md    (mul_md),
      .out_side (div_side),
      .out_neg  (div_neg),
      .out_ovf  (div_ovf),
      .out_q    (div_q)
   );

   // Output stage: sign, offset, clamp, status
   logic [34:0] qs, r;
   logic [31:0] val_in;
   logic [1:0]  st_in;
   logic        sat;

   always_comb begin
      qs  = div_neg ? (35'd0 - {2'd0, div_q}) : {2'd0, div_q};
      r   = qs + {{3{cfg_ff.si_min[31]}}, cfg_ff.si_min};
      sat = div_side.sat;
      if (div_ovf) begin
         sat    = 1'b1;
         val_in = div_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (!r[34] && (r[33:31] != 3'd0)) begin
         sat    = 1'b1;
         val_in = 32'h7FFF_FFFF;
      end else if (r[34] && (r[33:31] != 3'b111)) begin
         sat    = 1'b1;
         val_in = 32'h8000_0000;
      end else begin
         val_in = r[31:0];
      end
      st_in = sat ? ST_SAT : ST_OK;
      if (div_side.err != ST_OK) begin
         val_in = 32'd0;
         st_in  = div_side.err;
      end
   end

   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_side.vld;
      end
      rsp_value_ff  <= val_in;
      rsp_status_ff <= st_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scaled_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// File: verif/sensor_value_decode_and_rescale_top_tb.sv
module sensor_value_decode_and_rescale_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import svdr_pkg::*;

   localparam int WDOG_LIMIT = 1000;
   localparam int PIPE_WAIT  = 60;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  status;
   } reading_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [IDX_W-1:0]     req_value_index;
   logic [31:0]          req_raw_word;
   logic                 rsp_valid;
   logic signed [31:0]   rsp_scaled_value;
   logic [1:0]           rsp_status;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   // shadow copy of the block's registers
   cfg_type     shadow_cfg;
   reading_type pending_readings[$];
   int          err_cnt;
   int          items_sent;
   int          readings_seen;
   int          sat_seen;
   int          idle_cycles;

   sensor_value_decode_and_rescale_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value_index  (req_value_index),
      .req_raw_word     (req_raw_word),
      .rsp_valid        (rsp_valid),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // float to decimal fixed point, round half up on right shifts
   function automatic longint float_fixed(logic [31:0] w, ref bit sat);
      logic [63:0] mag;
      logic [63:0] lim;
      int          dp;
      int          k;
      bit          over;
      over = 1'b0;
      lim  = w[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      dp   = (shadow_cfg.dec_places > 9) ? 9 : int'(shadow_cfg.dec_places);
      if (w[30:23] == 8'd0) return 0;
      if (w[30:23] == 8'd255) begin
         sat = 1'b1;
         return w[31] ? -longint'(64'h8000_0000) : longint'(64'h7FFF_FFFF);
      end
      mag = {40'd0, 1'b1, w[22:0]};
      repeat (dp) mag = mag * 10;
      if (w[30:23] < 150) begin
         k = 150 - int'(w[30:23]);
         if (k >= 64) mag = 0;
         else mag = (mag + (64'd1 << (k - 1))) >> k;
      end else begin
         k = int'(w[30:23]) - 150;
         if (k >= 40 || mag > (lim >> k)) over = 1'b1;
         else mag = mag << k;
      end
      if (over || mag > lim) begin
         sat = 1'b1;
         mag = lim;
      end
      return w[31] ? -longint'(mag) : longint'(mag);
   endfunction

   // check index and span, decode by data type, then map linearly and clamp
   function automatic reading_type rescale(logic [2:0] idx, logic [31:0] w);
      reading_type res;
      bit          sat;
      longint      v, a, b, d, r;
      logic [63:0] ma, mb, md, q;
      bit          neg;
      logic [15:0] be;
      sat = 1'b0;
      res.value = '0;
      if (idx >= shadow_cfg.val_count || idx >= MAX_VALUES) begin
         res.status = ST_RANGE;
         return res;
      end
      d = longint'($signed(shadow_cfg.raw_max)) - longint'($signed(shadow_cfg.raw_min));
      if (d == 0) begin
         res.status = ST_SPAN;
         return res;
      end
      be = {w[7:0], w[15:8]};
      case (shadow_cfg.fmt)
         DT_U8:    v = longint'(w[7:0]);
         DT_S8:    v = longint'($signed(w[7:0]));
         DT_U16:   v = longint'(w[15:0]);
         DT_S16:   v = longint'($signed(w[15:0]));
         DT_S16BE: v = longint'($signed(be));
         DT_U32,
         DT_S32:   v = longint'($signed(w));
         default:  v = float_fixed(w, sat);
      endcase
      a  = v - longint'($signed(shadow_cfg.raw_min));
      b  = longint'($signed(shadow_cfg.si_max)) - longint'($signed(shadow_cfg.si_min));
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      md = (d < 0) ? -d : d;
      q  = (ma * mb) / md;
      neg = ((a < 0) != (b < 0)) != (d < 0);
      if (q > 64'h1_0000_0000) begin
         sat = 1'b1;
         r = neg ? -longint'(64'h8000_0000) : longint'(64'h7FFF_FFFF);
      end else begin
         r = (neg ? -longint'(q) : longint'(q)) + longint'($signed(shadow_cfg.si_min));
         if (r > 64'sh7FFF_FFFF) begin
            sat = 1'b1;
            r = 64'sh7FFF_FFFF;
         end else if (r < -64'sh8000_0000) begin
            sat = 1'b1;
            r = -64'sh8000_0000;
         end
      end
      res.value  = r[31:0];
      res.status = sat ? ST_SAT : ST_OK;
      return res;
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      reading_type exp_rd;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending_readings.size());
            $display("sensor_value_decode_and_rescale_top_tb: errors");
            $finish;
         end
         if (rsp_valid) begin
            readings_seen++;
            if (rsp_status == ST_SAT) sat_seen++;
            if (pending_readings.size() == 0) begin
               $error("unexpected result: value %h status %0d", rsp_scaled_value, rsp_status);
               err_cnt++;
            end else begin
               exp_rd = pending_readings.pop_front();
               if (rsp_scaled_value !== exp_rd.value) begin
                  $error("scaled_value: expected %h, got %h", exp_rd.value, rsp_scaled_value);
                  err_cnt++;
               end
               if (rsp_status !== exp_rd.status) begin
                  $error("status: expected %0d, got %0d", exp_rd.status, rsp_status);
                  err_cnt++;
               end
            end
         end
      end
   end

   // offer one item, hold until taken
   task automatic send_item(logic [2:0] idx, logic [31:0] w);
      start           <= 1'b1;
      req_value_index <= idx;
      req_raw_word    <= w;
      do @(posedge clock); while (busy);
      pending_readings.push_back(rescale(idx, w));
      items_sent++;
   endtask

   task automatic idle(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait for every outstanding result plus a margin that exceeds the pipeline depth
   task automatic drain();
      idle(1);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
   endtask

   task automatic put_reg(logic [2:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // all registers, written only once the block is empty
   task automatic configure(logic [2:0] dt, logic [3:0] dp, logic [3:0] nv,
                            logic [31:0] rmin, logic [31:0] rmax,
                            logic [31:0] smin, logic [31:0] smax);
      drain();
      put_reg(REG_FMT, {29'd0, dt});
      put_reg(REG_DEC_PLACES, {28'd0, dp});
      put_reg(REG_VAL_COUNT, {28'd0, nv});
      put_reg(REG_RAW_MIN, rmin);
      put_reg(REG_RAW_MAX, rmax);
      put_reg(REG_SI_MIN, smin);
      put_reg(REG_SI_MAX, smax);
      csr_we <= 1'b0;
      @(posedge clock);
      shadow_cfg.fmt        = dt;
      shadow_cfg.dec_places = dp;
      shadow_cfg.val_count  = nv;
      shadow_cfg.raw_min    = rmin;
      shadow_cfg.raw_max    = rmax;
      shadow_cfg.si_min     = smin;
      shadow_cfg.si_max     = smax;
   endtask

   // reset values: u8, one index, identity mapping
   task automatic test_reset_defaults();
      send_item(3'd0, 32'h0000_0000);
      send_item(3'd0, 32'hFFFF_FFFF);
      send_item(3'd1, 32'h0000_0005);
      send_item(3'd7, 32'h0000_0005);
   endtask

   // each integer type with identity mapping at field extremes
   task automatic test_int_types();
      for (int t = DT_U8; t <= DT_S32; t++) begin
         configure(t[2:0], 4'd0, 4'd8, 32'd0, 32'd1, 32'd0, 32'd1);
         send_item(3'd0, 32'h0000_0000);
         send_item(3'd7, 32'hFFFF_FFFF);
         send_item(3'd3, 32'h8000_0080);
         send_item(3'd5, 32'h7FFF_7F7F);
      end
   endtask

   // zero, denormal, infinities, NaN, half rounding, overflow, clamped decimal places
   task automatic test_float();
      configure(DT_FLOAT, 4'd0, 4'd8, 32'd0, 32'd1, 32'd0, 32'd1);
      send_item(3'd0, 32'h0000_0000);
      send_item(3'd0, 32'h0000_0001);
      send_item(3'd1, 32'h7F80_0000);
      send_item(3'd1, 32'hFF80_0000);
      send_item(3'd2, 32'h7FC0_0000);
      send_item(3'd2, 32'h3F00_0000);
      send_item(3'd3, 32'hBF00_0000);
      send_item(3'd3, 32'h4F00_0000);
      send_item(3'd4, 32'hCF00_0000);
      configure(DT_FLOAT, 4'd15, 4'd8, 32'd0, 32'd1, 32'd0, 32'd1);
      send_item(3'd0, 32'h3F80_0000);
      send_item(3'd0, 32'h4000_0000);
      send_item(3'd1, 32'h3DCC_CCCD);
      send_item(3'd1, 32'hBF80_0000);
   endtask

   // bad index, zero span and clamped mapping
   task automatic test_errors();
      configure(DT_S32, 4'd0, 4'd0, 32'd0, 32'd1, 32'd0, 32'd1);
      send_item(3'd0, 32'd1);
      configure(DT_S32, 4'd0, 4'd8, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1);
      send_item(3'd0, 32'd1);
      configure(DT_S32, 4'd0, 4'd8, 32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(3'd0, 32'h7FFF_FFFF);
      send_item(3'd0, 32'h8000_0000);
      configure(DT_S32, 4'd0, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000);
      send_item(3'd7, 32'h8000_0000);
      send_item(3'd7, 32'h7FFF_FFFF);
   endtask

   function automatic logic [31:0] rand_bound();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($urandom_range(0, 2000)) - 32'd1000;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(0, 70000)) - 32'd35000;
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      logic [7:0] e;
      if (shadow_cfg.fmt != DT_FLOAT) return $urandom();
      case ($urandom_range(0, 9))
         0:       e = $urandom_range(0, 1) ? 8'd0 : 8'd255;
         1, 2:    e = 8'($urandom());
         default: e = 8'($urandom_range(100, 165));
      endcase
      return {$urandom_range(0, 1) == 1, e, 23'($urandom())};
   endfunction

   // random settings, items in bursts with random gaps
   task automatic test_random(int n_items);
      int left;
      int burst;
      logic [31:0] rmin, rmax;
      left = n_items;
      while (left > 0) begin
         rmin = rand_bound();
         rmax = ($urandom_range(0, 19) == 0) ? rmin : rand_bound();
         configure(3'($urandom()), 4'($urandom()),
                   $urandom_range(0, 3) == 0 ? 4'($urandom()) : 4'd8,
                   rmin, rmax, rand_bound(), rand_bound());
         for (int i = 0; i < 160 && left > 0; i += burst) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
               send_item(3'($urandom()), rand_word());
               left--;
            end
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 15));
         end
      end
   endtask

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_value_index <= '0;
      req_raw_word    <= '0;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      err_cnt       = 0;
      items_sent    = 0;
      readings_seen = 0;
      sat_seen      = 0;
      idle_cycles   = 0;
      shadow_cfg = '{fmt: DT_U8, dec_places: 4'd0, val_count: 4'd1,
                     raw_min: 32'd0, raw_max: 32'd1, si_min: 32'd0, si_max: 32'd1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_int_types();
      test_float();
      test_errors();
      test_random(1950);
      drain();

      if (pending_readings.size() != 0) err_cnt++;
      $display("%0d items sent, %0d results checked, %0d saturated", items_sent,
               readings_seen, sat_seen);
      $display("covered all data types, float specials, range/span errors, random scaling");
      if (err_cnt == 0) begin
         $display("sensor_value_decode_and_rescale_top_tb: clean");
      end else begin
         $display("sensor_value_decode_and_rescale_top_tb: errors");
      end
      $finish;
   end

endmodule

// File: sensor_value_decode_and_rescale_top.f
rtl/svdr_pkg.sv
rtl/svdr_decode.sv
rtl/svdr_mult.sv
rtl/svdr_div.sv
rtl/sensor_value_decode_and_rescale_top.sv
verif/sensor_value_decode_and_rescale_top_tb.sv
